FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RILB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RILB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rilb_pkg.sv
// ----------------------------------------------------------------------------
// rilb_pkg
// constants, types and arithmetic helpers of the row iir low-pass filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rilb_pkg;

  // sizing
  localparam int unsigned MAX_WIDTH          = 2048;
  localparam int unsigned COEF_FRACTION_BITS = 16;

  // fixed field widths
  localparam int unsigned PIX_W       = 8;
  localparam int unsigned COLUMN_W    = 11;
  localparam int unsigned STRENGTH_W  = 17;
  localparam int unsigned ROW_WIDTH_W = 12;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CFG_IDX_W   = 1;

  // derived widths
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned W_W       = $clog2(MAX_WIDTH + 1);
  localparam int unsigned ADDR_W    = COL_W + 1;
  localparam int unsigned RAM_DEPTH = 2 ** ADDR_W;
  localparam int unsigned COEF_W    = COEF_FRACTION_BITS + 2;
  localparam int unsigned PROD_W    = COEF_W + PIX_W;
  localparam int unsigned SUM_W     = COEF_W + 10;

  localparam int unsigned MIN_WIDTH = 4;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = ROW_WIDTH_W'(2048);
  localparam logic [STRENGTH_W-1:0]  ONE_Q16 = STRENGTH_W'(65536);
  localparam logic [PIX_W-1:0]       PIX_MAX = {PIX_W{1'b1}};

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_DRAIN = 1'b1
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRENGTH  = CFG_IDX_W'(0),
    REG_ROW_WIDTH = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef struct packed {
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
    logic [COEF_W-1:0] cm;
  } coef_t;

  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] x;
    logic [COL_W-1:0] col;
    logic             bank;
    logic             pass_thru;
  } fwd_req_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
    logic             bank;
    logic             pass_thru;
    logic             last;
  } emit_req_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
  } wr_port_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_port_t;

  function automatic logic [STRENGTH_W-1:0] clamp_pole(input logic [STRENGTH_W-1:0] s);
    return (s > ONE_Q16) ? ONE_Q16 : s;
  endfunction

  // a = (1-r)^2 in q2.f
  function automatic logic [COEF_W-1:0] calc_coef_a(input logic [STRENGTH_W-1:0] s);
    logic [STRENGTH_W-1:0]   q;
    logic [2*STRENGTH_W-1:0] sq;
    logic [63:0]             t;
    q  = ONE_Q16 - clamp_pole(s);
    sq = (2*STRENGTH_W)'(q) * (2*STRENGTH_W)'(q);
    t  = (64'(sq) << COEF_FRACTION_BITS) >> 32;
    return COEF_W'(t);
  endfunction

  // b = 2r in q2.f
  function automatic logic [COEF_W-1:0] calc_coef_b(input logic [STRENGTH_W-1:0] s);
    logic [63:0] t;
    t = (64'(clamp_pole(s)) << (COEF_FRACTION_BITS + 1)) >> 16;
    return COEF_W'(t);
  endfunction

  // magnitude of c = -r^2 in q2.f
  function automatic logic [COEF_W-1:0] calc_coef_cm(input logic [STRENGTH_W-1:0] s);
    logic [STRENGTH_W-1:0]   r;
    logic [2*STRENGTH_W-1:0] sq;
    logic [63:0]             t;
    r  = clamp_pole(s);
    sq = (2*STRENGTH_W)'(r) * (2*STRENGTH_W)'(r);
    t  = (64'(sq) << COEF_FRACTION_BITS) >> 32;
    return COEF_W'(t);
  endfunction

  localparam coef_t COEF_RESET = '{
    a:  calc_coef_a('0),
    b:  calc_coef_b('0),
    cm: calc_coef_cm('0)
  };

  // ax + b*y1 - cm*y2, truncated to integer and clipped to pixel range
  function automatic logic [PIX_W-1:0] rilb_filt(input logic [PROD_W-1:0] ax,
                                                 input logic [PIX_W-1:0]  y1,
                                                 input logic [PIX_W-1:0]  y2,
                                                 input coef_t             c);
    logic [PROD_W-1:0]       by1;
    logic [PROD_W-1:0]       cy2;
    logic signed [SUM_W-1:0] s;
    logic [SUM_W-1:0]        v;
    logic [PIX_W-1:0]        res;
    by1 = PROD_W'(c.b) * PROD_W'(y1);
    cy2 = PROD_W'(c.cm) * PROD_W'(y2);
    s   = $signed(SUM_W'(ax)) + $signed(SUM_W'(by1)) - $signed(SUM_W'(cy2));
    v   = $unsigned(s) >> COEF_FRACTION_BITS;
    if (s < 0) begin
      res = '0;
    end else if (v > SUM_W'(PIX_MAX)) begin
      res = PIX_MAX;
    end else begin
      res = PIX_W'(v);
    end
    return res;
  endfunction

endpackage

FILE: rtl/rilb_if.sv
// ----------------------------------------------------------------------------
// rilb interfaces
// valid/ready channels for pixel beats, result beats and register writes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface rilb_in_if import rilb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output action, output pixel_in, input ready);
  modport sink   (input valid, input action, input pixel_in, output ready);
endinterface

interface rilb_out_if import rilb_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PIX_W-1:0]    pixel_out;
  logic [COLUMN_W-1:0] column;
  logic                last_of_row;

  modport source (output valid, output pixel_out, output column, output last_of_row,
                  input ready);
  modport sink   (input valid, input pixel_out, input column, input last_of_row,
                  output ready);
endinterface

interface rilb_cfg_if import rilb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/rilb_ram.sv
// ----------------------------------------------------------------------------
// rilb_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rilb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic                 re_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rilb_ctrl.sv
// ----------------------------------------------------------------------------
// rilb_ctrl
// register file, column counters and bank select; issues per-beat requests
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rilb_ctrl import rilb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rilb_in_if.sink   in_if,
  rilb_cfg_if.sink  cfg_if,
  input  logic      take_ok_i,
  output coef_t     coef_o,
  output fwd_req_t  fwd_req_o,
  output emit_req_t emit_req_o
);

  coef_t                  coef_q, coef_d;
  logic [ROW_WIDTH_W-1:0] row_width_q, row_width_d;
  logic [COL_W-1:0]       in_column_q, in_column_d;
  logic [COL_W-1:0]       out_column_q, out_column_d;
  logic [W_W-1:0]         pend_len_q, pend_len_d;
  logic                   write_bank_q, write_bank_d;
  logic                   row_pending_q, row_pending_d;

  logic           accept;
  logic           is_pixel;
  logic [W_W-1:0] eff_w;
  logic [W_W:0]   in_col_x;
  logic [W_W:0]   out_col_x;
  logic           f_pass;
  logic           row_end;
  logic           e_pass;
  logic           e_last;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready  = take_ok_i;
  assign accept       = in_if.valid && take_ok_i;
  assign is_pixel     = action_e'(in_if.action) == ACT_PIXEL;

  // register writes
  always_comb begin
    coef_d      = coef_q;
    row_width_d = row_width_q;
    if (cfg_if.valid) begin
      case (cfg_reg_e'(cfg_if.index))
        REG_STRENGTH: begin
          coef_d.a  = calc_coef_a(cfg_if.wdata[STRENGTH_W-1:0]);
          coef_d.b  = calc_coef_b(cfg_if.wdata[STRENGTH_W-1:0]);
          coef_d.cm = calc_coef_cm(cfg_if.wdata[STRENGTH_W-1:0]);
        end
        REG_ROW_WIDTH: begin
          row_width_d = cfg_if.wdata[ROW_WIDTH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // width clamp and edge detection
  always_comb begin
    if (row_width_q < ROW_WIDTH_W'(MIN_WIDTH)) begin
      eff_w = W_W'(MIN_WIDTH);
    end else if (32'(row_width_q) > MAX_WIDTH) begin
      eff_w = W_W'(MAX_WIDTH);
    end else begin
      eff_w = W_W'(row_width_q);
    end
    in_col_x  = (W_W+1)'(in_column_q);
    out_col_x = (W_W+1)'(out_column_q);
    f_pass    = (in_column_q <= COL_W'(1)) ||
                (in_col_x + (W_W+1)'(2) >= (W_W+1)'(eff_w));
    row_end   = in_col_x + (W_W+1)'(1) >= (W_W+1)'(eff_w);
    e_pass    = (out_column_q <= COL_W'(1)) ||
                (out_col_x + (W_W+1)'(2) >= (W_W+1)'(pend_len_q));
    e_last    = out_column_q == '0;
  end

  // emit first from the stored row, then take the new pixel
  always_comb begin
    in_column_d   = in_column_q;
    out_column_d  = out_column_q;
    pend_len_d    = pend_len_q;
    write_bank_d  = write_bank_q;
    row_pending_d = row_pending_q;
    if (accept) begin
      if (row_pending_q) begin
        if (e_last) begin
          row_pending_d = 1'b0;
        end else begin
          out_column_d = out_column_q - COL_W'(1);
        end
      end
      if (is_pixel) begin
        if (row_end) begin
          pend_len_d    = W_W'(in_col_x + (W_W+1)'(1));
          out_column_d  = in_column_q;
          row_pending_d = 1'b1;
          write_bank_d  = ~write_bank_q;
          in_column_d   = '0;
        end else begin
          in_column_d = in_column_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q        <= COEF_RESET;
      row_width_q   <= ROW_WIDTH_RESET;
      in_column_q   <= '0;
      out_column_q  <= '0;
      pend_len_q    <= '0;
      write_bank_q  <= 1'b0;
      row_pending_q <= 1'b0;
    end else begin
      coef_q        <= coef_d;
      row_width_q   <= row_width_d;
      in_column_q   <= in_column_d;
      out_column_q  <= out_column_d;
      pend_len_q    <= pend_len_d;
      write_bank_q  <= write_bank_d;
      row_pending_q <= row_pending_d;
    end
  end

  assign coef_o = coef_q;

  always_comb begin
    fwd_req_o.valid     = accept && is_pixel;
    fwd_req_o.x         = in_if.pixel_in;
    fwd_req_o.col       = in_column_q;
    fwd_req_o.bank      = write_bank_q;
    fwd_req_o.pass_thru = f_pass;

    emit_req_o.valid     = accept && row_pending_q;
    emit_req_o.col       = out_column_q;
    emit_req_o.bank      = ~write_bank_q;
    emit_req_o.pass_thru = e_pass;
    emit_req_o.last      = e_last;
  end

  `RILB_ASSERT_NXT(a_row_end_swaps, accept && is_pixel && row_end, row_pending_q && (write_bank_q != $past(write_bank_q)), "row end did not swap banks")
  `RILB_ASSERT_IMP(a_out_col_in_row, row_pending_q, 32'(out_column_q) < 32'(pend_len_q), "emit column beyond stored row")

endmodule

FILE: rtl/rilb_fwd.sv
// ----------------------------------------------------------------------------
// rilb_fwd
// left-to-right recursion, writes each filtered pixel into the row store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rilb_fwd import rilb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  coef_t    coef_i,
  input  fwd_req_t req_i,
  output wr_port_t wr_o
);

  logic              p1_v_q;
  logic [PIX_W-1:0]  p1_x_q;
  logic [PROD_W-1:0] p1_ax_q;
  logic [COL_W-1:0]  p1_col_q;
  logic              p1_bank_q;
  logic              p1_pass_q;
  logic [PIX_W-1:0]  fwd1_q, fwd2_q;
  logic [PIX_W-1:0]  y;

  // product with the input term is taken ahead of the feedback loop
  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      p1_x_q    <= req_i.x;
      p1_ax_q   <= PROD_W'(coef_i.a) * PROD_W'(req_i.x);
      p1_col_q  <= req_i.col;
      p1_bank_q <= req_i.bank;
      p1_pass_q <= req_i.pass_thru;
    end
  end

  assign y = p1_pass_q ? p1_x_q : rilb_filt(p1_ax_q, fwd1_q, fwd2_q, coef_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      fwd1_q <= '0;
      fwd2_q <= '0;
    end else begin
      p1_v_q <= req_i.valid;
      if (p1_v_q) begin
        fwd2_q <= fwd1_q;
        fwd1_q <= y;
      end
    end
  end

  assign wr_o.en   = p1_v_q;
  assign wr_o.addr = {p1_bank_q, p1_col_q};
  assign wr_o.data = y;

  `RILB_ASSERT_IMP(a_edge_unfiltered, wr_o.en && (p1_col_q <= COL_W'(1)), wr_o.data == p1_x_q, "left edge pixel was filtered")

endmodule

FILE: rtl/rilb_bwd.sv
// ----------------------------------------------------------------------------
// rilb_bwd
// right-to-left recursion over the stored row, with output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rilb_bwd import rilb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  coef_t             coef_i,
  input  emit_req_t         emit_req_i,
  input  wr_port_t          wr_i,
  output rd_port_t          rd_o,
  input  logic [PIX_W-1:0]  rd_data_i,
  output logic              take_ok_o,
  rilb_out_if.source        out_if
);

  // e1: ram read in flight
  logic             e1_v_q, e1_v_d;
  logic [COL_W-1:0] e1_col_q;
  logic             e1_pass_q;
  logic             e1_last_q;
  logic             byp_hit_q;
  logic [PIX_W-1:0] byp_data_q;
  // e2: stored pixel and its input product
  logic              e2_v_q, e2_v_d;
  logic [PIX_W-1:0]  e2_f_q;
  logic [PROD_W-1:0] e2_ax_q;
  logic [COL_W-1:0]  e2_col_q;
  logic              e2_pass_q;
  logic              e2_last_q;
  // output register
  logic             out_v_q, out_v_d;
  logic [PIX_W-1:0] out_pix_q;
  logic [COL_W-1:0] out_col_q;
  logic             out_last_q;
  logic [PIX_W-1:0] bwd1_q, bwd2_q;

  logic             out_free, e2_free, e1_free;
  logic             e2_load, out_load;
  logic [PIX_W-1:0] f;
  logic [PIX_W-1:0] y;

  assign out_free  = !out_v_q || out_if.ready;
  assign e2_free   = !e2_v_q || out_free;
  assign e1_free   = !e1_v_q || e2_free;
  assign take_ok_o = e1_free;
  assign e2_load   = e1_v_q && e2_free;
  assign out_load  = e2_v_q && out_free;

  assign rd_o.en   = emit_req_i.valid;
  assign rd_o.addr = {emit_req_i.bank, emit_req_i.col};

  // last pixel of a row can be read in the same cycle it is written
  assign f = byp_hit_q ? byp_data_q : rd_data_i;
  assign y = e2_pass_q ? e2_f_q : rilb_filt(e2_ax_q, bwd1_q, bwd2_q, coef_i);

  always_comb begin
    e1_v_d  = e1_v_q;
    e2_v_d  = e2_v_q;
    out_v_d = out_v_q;
    if (e1_free) begin
      e1_v_d = emit_req_i.valid;
    end
    if (e2_free) begin
      e2_v_d = e1_v_q;
    end
    if (out_free) begin
      out_v_d = e2_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q  <= 1'b0;
      e2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      bwd1_q  <= '0;
      bwd2_q  <= '0;
    end else begin
      e1_v_q  <= e1_v_d;
      e2_v_q  <= e2_v_d;
      out_v_q <= out_v_d;
      if (out_load) begin
        bwd2_q <= bwd1_q;
        bwd1_q <= y;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_req_i.valid) begin
      e1_col_q   <= emit_req_i.col;
      e1_pass_q  <= emit_req_i.pass_thru;
      e1_last_q  <= emit_req_i.last;
      byp_hit_q  <= wr_i.en && (wr_i.addr == rd_o.addr);
      byp_data_q <= wr_i.data;
    end
    if (e2_load) begin
      e2_f_q    <= f;
      e2_ax_q   <= PROD_W'(coef_i.a) * PROD_W'(f);
      e2_col_q  <= e1_col_q;
      e2_pass_q <= e1_pass_q;
      e2_last_q <= e1_last_q;
    end
    if (out_load) begin
      out_pix_q  <= y;
      out_col_q  <= e2_col_q;
      out_last_q <= e2_last_q;
    end
  end

  assign out_if.valid       = out_v_q;
  assign out_if.pixel_out   = out_pix_q;
  assign out_if.column      = COLUMN_W'(out_col_q);
  assign out_if.last_of_row = out_last_q;

  `RILB_ASSERT_IMP(a_read_slot, emit_req_i.valid, e1_free, "read issued while e1 is held")
  `RILB_ASSERT_IMP(a_last_is_col0, out_v_q && out_last_q, out_col_q == '0, "row end flag off column zero")

endmodule

FILE: rtl/row_iir_lowpass_bidirectional.sv
// ----------------------------------------------------------------------------
// row_iir_lowpass_bidirectional
// Second-order recursive low-pass over 8-bit grey rows, run left to right on
// the incoming row and right to left over the stored result. One beat is
// taken per clock unless the input is held; each pixel beat is filtered and
// written into one bank of a two-bank row store while, in the same beat, the
// previous row is read back from the other bank and emitted from its last
// column down to column 0, one result per beat, column 0 flagged as last. The
// two pixels at each end of a row pass unfiltered in both directions. Drain
// beats carry no pixel and only push out the stored row; once all rows are
// in, one drain per remaining column empties it. A row that ends before its
// predecessor is fully emitted drops the rest of the predecessor. A result
// passes the read stage e1 and stage e2 before the output register; the
// sustained rate of one beat per clock is set by the feedback loop of each
// direction and by the row store, which takes one write and one read every
// clock. The output register plus two more stages absorb a stall of the
// result channel before the input channel is held. The pole r (strength,
// Q1.16, 1.0 = 65536) sets A = (1-r)^2, B = 2r, C = -r^2 in Q2.16; register
// writes are taken at any time but must only come while no beat is in
// flight. The row store has no reset and needs no clearing pass: only
// entries of the current stored row are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module row_iir_lowpass_bidirectional import rilb_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  rilb_in_if.sink    in_if,
  rilb_out_if.source out_if,
  rilb_cfg_if.sink   cfg_if
);

  coef_t            coef;
  fwd_req_t         fwd_req;
  emit_req_t        emit_req;
  wr_port_t         wr;
  rd_port_t         rd;
  logic [PIX_W-1:0] rd_data;
  logic             take_ok;

  // registers, column counters, bank swap at row end
  rilb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .cfg_if     (cfg_if),
    .take_ok_i  (take_ok),
    .coef_o     (coef),
    .fwd_req_o  (fwd_req),
    .emit_req_o (emit_req)
  );

  // left-to-right pass, one write per pixel beat
  rilb_fwd u_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .req_i  (fwd_req),
    .wr_o   (wr)
  );

  // two banks of one row each, bank select is the top address bit
  rilb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (RAM_DEPTH)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (rd.en),
    .raddr_i (rd.addr),
    .rdata_o (rd_data)
  );

  // right-to-left pass and result register; also paces the input side
  rilb_bwd u_bwd (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .coef_i     (coef),
    .emit_req_i (emit_req),
    .wr_i       (wr),
    .rd_o       (rd),
    .rd_data_i  (rd_data),
    .take_ok_o  (take_ok),
    .out_if     (out_if)
  );

endmodule

FILE: tb/sv/row_iir_lowpass_bidirectional_check.sv
// ----------------------------------------------------------------------------
// row_iir_lowpass_bidirectional_check
// Watches the pixel, result and register channels and keeps its own model of
// the forward/backward row filter. Every pixel or drain beat taken adds the
// result it should cause, if any, to a queue, and every result beat is
// checked field by field against the oldest entry in that queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module row_iir_lowpass_bidirectional_check import rilb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rilb_in_if          in_mon,
  rilb_out_if         out_mon,
  rilb_cfg_if         cfg_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned awaited_cnt_o,
  output int unsigned checked_cnt_o
);

  typedef struct packed {
    logic [PIX_W-1:0]    pix;
    logic [COLUMN_W-1:0] col;
    logic                last;
  } out_beat_t;

  // register copies
  logic [STRENGTH_W-1:0]  pole;
  logic [ROW_WIDTH_W-1:0] width_reg;

  // two banks of forward-filtered rows
  logic [PIX_W-1:0] row_mem [2*MAX_WIDTH];
  logic [PIX_W-1:0] fwd_y1, fwd_y2, bwd_y1, bwd_y2;
  int unsigned      in_col, out_col, stored_len;
  logic             fill_bank, row_waiting;

  out_beat_t awaited_q[$];
  out_beat_t want;

  // one step of y = A*x + B*y1 - Cm*y2, truncated and clipped to a pixel
  function automatic logic [PIX_W-1:0] iir_tap(input logic [PIX_W-1:0] x,
                                               input logic [PIX_W-1:0] y1,
                                               input logic [PIX_W-1:0] y2);
    longint unsigned r, q;
    longint          ca, cb, cc, acc;
    r = pole;
    if (r > ONE_Q16) r = ONE_Q16;
    q   = 64'(ONE_Q16) - r;
    ca  = longint'(((q * q) << COEF_FRACTION_BITS) >> 32);
    cb  = longint'(((2 * r) << COEF_FRACTION_BITS) >> 16);
    cc  = longint'(((r * r) << COEF_FRACTION_BITS) >> 32);
    acc = ca * longint'(x) + cb * longint'(y1) - cc * longint'(y2);
    if (acc < 0) return '0;
    acc = acc >>> COEF_FRACTION_BITS;
    return (acc > longint'(PIX_MAX)) ? PIX_MAX : PIX_W'(acc);
  endfunction

  function automatic int unsigned clipped_width();
    int unsigned w;
    w = width_reg;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // backward pass: next pixel of the stored row, right to left
  function automatic void emit_stored();
    int unsigned      col;
    logic [PIX_W-1:0] f, y;
    if (!row_waiting) return;
    col = out_col % MAX_WIDTH;
    f   = row_mem[(fill_bank ? 0 : MAX_WIDTH) + col];
    if (col <= 1 || col + 2 >= stored_len) y = f;
    else y = iir_tap(f, bwd_y1, bwd_y2);
    bwd_y2 = bwd_y1;
    bwd_y1 = y;
    awaited_q.push_back('{pix: y, col: COLUMN_W'(col), last: (col == 0)});
    if (col == 0) row_waiting = 1'b0;
    else out_col = col - 1;
  endfunction

  // forward pass on a pixel beat, row hand-over at the end of a row
  function automatic void take_beat(input logic act, input logic [PIX_W-1:0] x);
    int unsigned      w, col;
    logic [PIX_W-1:0] y;
    emit_stored();
    if (act == ACT_DRAIN) return;
    w   = clipped_width();
    col = in_col % MAX_WIDTH;
    if (col <= 1 || col + 2 >= w) y = x;
    else y = iir_tap(x, fwd_y1, fwd_y2);
    fwd_y2 = fwd_y1;
    fwd_y1 = y;
    row_mem[(fill_bank ? MAX_WIDTH : 0) + col] = y;
    if (col + 1 >= w) begin
      stored_len  = col + 1;
      out_col     = col;
      row_waiting = 1'b1;
      fill_bank   = !fill_bank;
      in_col      = 0;
    end else begin
      in_col = col + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pole        = '0;
      width_reg   = ROW_WIDTH_RESET;
      fwd_y1      = '0;
      fwd_y2      = '0;
      bwd_y1      = '0;
      bwd_y2      = '0;
      in_col      = 0;
      out_col     = 0;
      stored_len  = 0;
      fill_bank   = 1'b0;
      row_waiting = 1'b0;
      awaited_q.delete();
      mismatch_cnt_o = 0;
      checked_cnt_o  = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_reg_e'(cfg_mon.index))
          REG_STRENGTH:  pole      = cfg_mon.wdata[STRENGTH_W-1:0];
          REG_ROW_WIDTH: width_reg = cfg_mon.wdata[ROW_WIDTH_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_beat(in_mon.action, in_mon.pixel_in);
      if (out_mon.valid && out_mon.ready) begin
        checked_cnt_o++;
        if (awaited_q.size() == 0) begin
          $error("result beat with nothing awaited: pixel_out %0d column %0d last_of_row %0b",
                 out_mon.pixel_out, out_mon.column, out_mon.last_of_row);
          mismatch_cnt_o++;
        end else begin
          want = awaited_q.pop_front();
          if (out_mon.pixel_out !== want.pix) begin
            $error("pixel_out: expected %0d, got %0d", want.pix, out_mon.pixel_out);
            mismatch_cnt_o++;
          end
          if (out_mon.column !== want.col) begin
            $error("column: expected %0d, got %0d", want.col, out_mon.column);
            mismatch_cnt_o++;
          end
          if (out_mon.last_of_row !== want.last) begin
            $error("last_of_row: expected %0b, got %0b", want.last, out_mon.last_of_row);
            mismatch_cnt_o++;
          end
        end
      end
    end
    awaited_cnt_o = awaited_q.size();
  end

endmodule

FILE: tb/sv/row_iir_lowpass_bidirectional_test.sv
// ----------------------------------------------------------------------------
// row_iir_lowpass_bidirectional_test
// Drives rows of grey pixels and drain beats into the bidirectional row
// filter under changing pole and row width settings, with bursty input and a
// stalling result side, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module row_iir_lowpass_bidirectional_test;
  import rilb_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 1500;
  localparam int unsigned FLUSH_DRAINS  = 40;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 300;  // long result-side hold-off
  localparam int unsigned QUIET_LIMIT   = 4000; // cycles without any beat
  localparam int unsigned CHOKE_PHASE   = 5;

  typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_RAMP, PIX_HOLD} pix_mode_e;
  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_SPARSE} rdy_mode_e;

  logic clk_i     = 1'b0;
  logic rst_ni    = 1'b0;
  logic choke_req = 1'b0;

  int unsigned mismatch_cnt, awaited_cnt, checked_cnt;
  int unsigned burst_left, pixels_sent, drains_sent, reg_writes, phase_cnt, quiet_cycles;

  rilb_in_if  in_if ();
  rilb_out_if out_if ();
  rilb_cfg_if cfg_if ();

  row_iir_lowpass_bidirectional dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  row_iir_lowpass_bidirectional_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .cfg_mon        (cfg_if),
    .mismatch_cnt_o (mismatch_cnt),
    .awaited_cnt_o  (awaited_cnt),
    .checked_cnt_o  (checked_cnt)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // next pixel of a row, in the flavor chosen for the phase
  function automatic logic [PIX_W-1:0] next_pixel(input pix_mode_e mode,
                                                  input logic [PIX_W-1:0] prev);
    int v;
    case (mode)
      PIX_UNIFORM: return PIX_W'($urandom);
      PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? PIX_MAX : '0;
      PIX_RAMP: begin
        // slow wander, clipped at both ends
        v = int'(prev) + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > int'(PIX_MAX)) v = int'(PIX_MAX);
        return PIX_W'(v);
      end
      default: return ($urandom_range(0, 15) == 0) ? PIX_W'($urandom) : prev;
    endcase
  endfunction

  // one pixel or drain beat; called and returns at a falling edge, and leaves
  // valid high so that the next beat of a burst follows without a gap
  task automatic offer(input action_e act, input logic [PIX_W-1:0] px);
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_if.valid    = 1'b1;
    in_if.action   = act;
    in_if.pixel_in = px;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (act == ACT_DRAIN) drains_sent++;
    else pixels_sent++;
  endtask

  // drop valid, wait for every awaited result, then let the pipe empty
  task automatic settle();
    in_if.valid = 1'b0;
    while (awaited_cnt != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.wdata = CFG_DATA_W'(val);
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
    reg_writes++;
  endtask

  // result side: ready follows a 16-bit pattern that repeats until it is
  // redrawn; once, on request, it holds off for a long stretch so that the
  // block fills up and holds its input
  initial begin
    rdy_mode_e   mode;
    logic [15:0] pat;
    bit          held;
    held         = 1'b0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = rdy_mode_e'($urandom_range(0, 3));
      case (mode)
        RDY_ALWAYS: pat = '1;
        RDY_COIN:   pat = 16'($urandom);
        RDY_MOSTLY: pat = 16'($urandom) | 16'($urandom);
        default:    pat = 16'($urandom) & 16'($urandom) | 16'h0001;
      endcase
      for (int k = 0; k < 32; k++) begin
        @(negedge clk_i);
        if (choke_req && !held) begin
          held         = 1'b1;
          out_if.ready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk_i);
        end
        out_if.ready = pat[k % 16];
      end
    end
  end

  // watchdog: any stretch without a single beat on any channel is a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: %0d cycles without a beat, %0d results still awaited",
                 quiet_cycles, awaited_cnt);
        $display("** row_iir_lowpass_bidirectional: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int unsigned      n, drain_pct, pix_goal, s, w;
    pix_mode_e        mode;
    logic [PIX_W-1:0] px;

    in_if.valid    = 1'b0;
    in_if.action   = ACT_PIXEL;
    in_if.pixel_in = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = REG_STRENGTH;
    cfg_if.wdata   = '0;
    burst_left     = 0;
    px             = '0;

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ---------------- directed part ----------------

    // drains with no row stored cause nothing
    offer(ACT_DRAIN, PIX_MAX);
    offer(ACT_DRAIN, '0);

    // start a row at the reset width, then shrink the width mid-row: a width
    // below the minimum acts as four, so the next pixel closes the row
    offer(ACT_PIXEL, '0);
    offer(ACT_PIXEL, PIX_MAX);
    offer(ACT_PIXEL, 8'd17);
    settle();
    write_reg(REG_ROW_WIDTH, 0);
    offer(ACT_PIXEL, 8'd128);

    // pole above one acts as one: y = 2*y1 - y2, so the forward pass clips
    // high and the backward pass clips a negative sum to zero
    settle();
    write_reg(REG_STRENGTH, 131071);
    write_reg(REG_ROW_WIDTH, 6);
    offer(ACT_PIXEL, '0);
    offer(ACT_PIXEL, PIX_MAX);
    offer(ACT_PIXEL, 8'd90);
    offer(ACT_PIXEL, 8'd200);
    offer(ACT_PIXEL, '0);
    offer(ACT_PIXEL, PIX_MAX);

    // a four-pixel row ends while two columns of the six-pixel row are left,
    // those two are dropped; at width four every pixel passes unfiltered
    settle();
    write_reg(REG_ROW_WIDTH, 4);
    offer(ACT_PIXEL, 8'd3);
    offer(ACT_PIXEL, 8'd250);
    offer(ACT_PIXEL, 8'd1);
    offer(ACT_PIXEL, 8'd77);
    repeat (4) offer(ACT_DRAIN, PIX_W'($urandom));

    // ---------------- random phases ----------------
    // mostly rows of random content under a fresh setting per phase, mixed
    // with drain beats; the width is often left alone so rows cross phases
    pix_goal = pixels_sent + RANDOM_PIXELS;
    while (pixels_sent < pix_goal) begin
      settle();
      phase_cnt++;
      if (phase_cnt == 1 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 6))
          0:       s = 0;
          1:       s = 1;
          2:       s = 65535;
          3:       s = ONE_Q16;
          4:       s = $urandom_range(65537, 131071);
          5:       s = $urandom_range(40000, 65535);
          default: s = $urandom_range(0, 65536);
        endcase
        write_reg(REG_STRENGTH, s);
      end
      if (phase_cnt == CHOKE_PHASE) begin
        // short rows so that results pile up during the hold-off
        write_reg(REG_ROW_WIDTH, 12);
      end else if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       w = $urandom_range(0, 3);
          1:       w = MIN_WIDTH;
          2:       w = $urandom_range(2049, 4095);
          3:       w = $urandom_range(100, 300);
          4:       w = 5;
          default: w = $urandom_range(5, 40);
        endcase
        write_reg(REG_ROW_WIDTH, w);
      end

      n = $urandom_range(20, 150);
      if (phase_cnt == CHOKE_PHASE) begin
        n         = 250;
        choke_req = 1'b1;
      end
      case ($urandom_range(0, 2))
        0:       drain_pct = 0;
        1:       drain_pct = $urandom_range(3, 10);
        default: drain_pct = $urandom_range(20, 50);
      endcase
      mode = pix_mode_e'($urandom_range(0, 3));
      repeat (n) begin
        if ($urandom_range(0, 99) < drain_pct) begin
          offer(ACT_DRAIN, PIX_W'($urandom));
        end else begin
          px = next_pixel(mode, px);
          offer(ACT_PIXEL, px);
        end
      end
    end

    // ---------------- flush ----------------
    // FLUSH_DRAINS drains push out up to as many columns of whatever row is still stored
    settle();
    repeat (FLUSH_DRAINS) offer(ACT_DRAIN, PIX_W'($urandom));
    settle();

    $display("run covered %0d pixel beats and %0d drain beats in %0d random phases,",
             pixels_sent, drains_sent, phase_cnt);
    $display("%0d register writes and %0d result beats compared",
             reg_writes, checked_cnt);
    if (mismatch_cnt == 0 && awaited_cnt == 0) begin
      $display("** row_iir_lowpass_bidirectional: PASSED **");
    end else begin
      $display("** row_iir_lowpass_bidirectional: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rilb_pkg.sv
rtl/rilb_if.sv
rtl/rilb_ram.sv
rtl/rilb_ctrl.sv
rtl/rilb_fwd.sv
rtl/rilb_bwd.sv
rtl/row_iir_lowpass_bidirectional.sv
tb/sv/row_iir_lowpass_bidirectional_check.sv
tb/sv/row_iir_lowpass_bidirectional_test.sv
